// ===== rtl/hrhp_pkg.sv =====
package hrhp_pkg;

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_SP    = 8'd32;
    localparam logic [7:0] CH_COLON = 8'd58;
    localparam logic [7:0] CH_0     = 8'd48;
    localparam logic [7:0] CH_9     = 8'd57;

    localparam logic [15:0] DEC_BASE = 16'd10;

    localparam int MAX_RES = 3;
    localparam int CNT_W   = $clog2(MAX_RES + 1);

    typedef enum logic [2:0] {
        K_TEXT  = 3'd0,
        K_NAME  = 3'd1,
        K_VALUE = 3'd2,
        K_HDONE = 3'd3,
        K_DROP  = 3'd4,
        K_BODY  = 3'd5,
        K_SUM   = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        ERR_OK         = 2'd0,
        ERR_INCOMPLETE = 2'd1,
        ERR_MALFORMED  = 2'd2,
        ERR_INVALID    = 2'd3
    } err_t;

    typedef enum logic [5:0] {
        PH_VERSION = 6'b000001,
        PH_CODE    = 6'b000010,
        PH_TEXT    = 6'b000100,
        PH_NAME    = 6'b001000,
        PH_VALUE   = 6'b010000,
        PH_BODY    = 6'b100000
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [15:0] code;
        logic        malformed;
        logic        invalid;
        logic        line_start;
        logic        skip_sp;
    } pstate_t;

    typedef struct packed {
        logic       emit;
        kind_t      kind;
        logic [7:0] data;
    } evt_t;

    typedef struct packed {
        pstate_t s;
        evt_t    e;
    } step_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        logic [15:0] code;
        err_t        err;
        logic        last;
    } res_t;

    typedef struct packed {
        res_t [MAX_RES-1:0] slot;
        logic [CNT_W-1:0]   count;
    } batch_t;

endpackage

// ===== rtl/hrhp_core.sv =====
module hrhp_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [7:0]        data_byte,
    input  logic              byte_valid,
    input  logic              end_of_response,
    output hrhp_pkg::batch_t  batch
);

    localparam hrhp_pkg::pstate_t ST_RESET = '{
        phase:      hrhp_pkg::PH_VERSION,
        code:       16'd0,
        malformed:  1'b0,
        invalid:    1'b0,
        line_start: 1'b1,
        skip_sp:    1'b0
    };

    function automatic hrhp_pkg::step_t content_step(hrhp_pkg::pstate_t s, logic [7:0] c);
        hrhp_pkg::step_t r;
        r   = '0;
        r.s = s;
        case (s.phase)
            hrhp_pkg::PH_VERSION:
            begin
                if (c == hrhp_pkg::CH_SP)
                begin
                    r.s.phase = hrhp_pkg::PH_CODE;
                end
            end
            hrhp_pkg::PH_CODE:
            begin
                if (c == hrhp_pkg::CH_SP)
                begin
                    r.s.phase = hrhp_pkg::PH_TEXT;
                end
                else if (c inside {[hrhp_pkg::CH_0:hrhp_pkg::CH_9]})
                begin
                    r.s.code = 16'(s.code * hrhp_pkg::DEC_BASE + 16'(c - hrhp_pkg::CH_0));
                end
                else
                begin
                    r.s.invalid = 1'b1;
                end
            end
            hrhp_pkg::PH_TEXT:
            begin
                r.e = '{emit: 1'b1, kind: hrhp_pkg::K_TEXT, data: c};
            end
            hrhp_pkg::PH_NAME:
            begin
                r.s.line_start = 1'b0;
                if (c == hrhp_pkg::CH_COLON)
                begin
                    r.s.phase   = hrhp_pkg::PH_VALUE;
                    r.s.skip_sp = 1'b1;
                end
                else
                begin
                    r.e = '{emit: 1'b1, kind: hrhp_pkg::K_NAME, data: c};
                end
            end
            hrhp_pkg::PH_VALUE:
            begin
                if (!(s.skip_sp && c == hrhp_pkg::CH_SP))
                begin
                    r.s.skip_sp = 1'b0;
                    r.e = '{emit: 1'b1, kind: hrhp_pkg::K_VALUE, data: c};
                end
            end
            default:
            begin
                r.e = '{emit: 1'b1, kind: hrhp_pkg::K_BODY, data: c};
            end
        endcase
        return r;
    endfunction

    function automatic hrhp_pkg::step_t line_end_step(hrhp_pkg::pstate_t s);
        hrhp_pkg::step_t r;
        r   = '0;
        r.s = s;
        r.s.line_start = 1'b1;
        r.s.skip_sp    = 1'b0;
        case (s.phase)
            hrhp_pkg::PH_VERSION:
            begin
                r.s.malformed = 1'b1;
                r.s.phase     = hrhp_pkg::PH_NAME;
            end
            hrhp_pkg::PH_CODE, hrhp_pkg::PH_TEXT:
            begin
                r.s.phase = hrhp_pkg::PH_NAME;
            end
            hrhp_pkg::PH_NAME:
            begin
                if (s.line_start)
                begin
                    r.s       = s;
                    r.s.phase = hrhp_pkg::PH_BODY;
                end
                else
                begin
                    r.e = '{emit: 1'b1, kind: hrhp_pkg::K_DROP, data: 8'd0};
                end
            end
            hrhp_pkg::PH_VALUE:
            begin
                r.e       = '{emit: 1'b1, kind: hrhp_pkg::K_HDONE, data: 8'd0};
                r.s.phase = hrhp_pkg::PH_NAME;
            end
            default:
            begin
                r.s = s;
            end
        endcase
        return r;
    endfunction

    hrhp_pkg::pstate_t st_reg, st_next;
    logic              held_reg, held_next;

    always_comb
    begin
        hrhp_pkg::step_t              sa;
        hrhp_pkg::step_t              sb;
        hrhp_pkg::err_t               err;
        hrhp_pkg::res_t [2:0]         ev;
        logic [2:0]                   ev_on;
        logic [hrhp_pkg::CNT_W-1:0]   n;

        sa        = '0;
        sa.s      = st_reg;
        sb        = '0;
        sb.s      = st_reg;
        held_next = held_reg;

        if (byte_valid)
        begin
            if (st_reg.phase == hrhp_pkg::PH_BODY)
            begin
                sa.e = '{emit: 1'b1, kind: hrhp_pkg::K_BODY, data: data_byte};
                sb.s = st_reg;
            end
            else if (held_reg)
            begin
                held_next = 1'b0;
                if (data_byte == hrhp_pkg::CH_LF)
                begin
                    sa = line_end_step(st_reg);
                    sb.s = sa.s;
                end
                else
                begin
                    sa = content_step(st_reg, hrhp_pkg::CH_CR);
                    sb.s = sa.s;
                    if (data_byte == hrhp_pkg::CH_CR)
                    begin
                        held_next = 1'b1;
                    end
                    else
                    begin
                        sb = content_step(sa.s, data_byte);
                    end
                end
            end
            else if (data_byte == hrhp_pkg::CH_CR)
            begin
                held_next = 1'b1;
            end
            else
            begin
                sa = content_step(st_reg, data_byte);
                sb.s = sa.s;
            end
        end

        if (sb.s.phase != hrhp_pkg::PH_BODY)
        begin
            err = hrhp_pkg::ERR_INCOMPLETE;
        end
        else if (sb.s.malformed)
        begin
            err = hrhp_pkg::ERR_MALFORMED;
        end
        else if (sb.s.invalid)
        begin
            err = hrhp_pkg::ERR_INVALID;
        end
        else
        begin
            err = hrhp_pkg::ERR_OK;
        end

        st_next = sb.s;
        if (end_of_response)
        begin
            st_next   = ST_RESET;
            held_next = 1'b0;
        end

        ev_on = {end_of_response, sb.e.emit, sa.e.emit};
        ev[0] = '{kind: sa.e.kind, data: sa.e.data, code: 16'd0,
                  err: hrhp_pkg::ERR_OK, last: 1'b0};
        ev[1] = '{kind: sb.e.kind, data: sb.e.data, code: 16'd0,
                  err: hrhp_pkg::ERR_OK, last: 1'b0};
        ev[2] = '{kind: hrhp_pkg::K_SUM, data: 8'd0,
                  code: (err == hrhp_pkg::ERR_OK) ? sb.s.code : 16'd0,
                  err: err, last: 1'b0};

        batch = '0;
        n     = '0;
        for (int i = 0; i < hrhp_pkg::MAX_RES; i++)
        begin
            if (ev_on[i])
            begin
                batch.slot[n] = ev[i];
                n = n + 1'b1;
            end
        end
        if (n != '0)
        begin
            batch.slot[n - 1'b1].last = 1'b1;
        end
        batch.count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_RESET;
            held_reg <= 1'b0;
        end
        else if (take)
        begin
            st_reg   <= st_next;
            held_reg <= held_next;
        end
    end

endmodule

// ===== rtl/http_response_header_parser_unit.sv =====
// A request's first result is registered on accept, presented in the next cycle.
// Throughput: one request per cycle; a request that yields k results (k up to 3)
// holds off the next request while the result buffer drains or out_stall is high.
// Reset (rst_n, async, active low) returns the parser to the version field, empties
// the result buffer and drops any held CR.
module http_response_header_parser_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        end_of_response,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [7:0]  out_byte,
    output logic [15:0] status_code,
    output logic [1:0]  error_code,
    output logic        last_of_run
);

    hrhp_pkg::batch_t                         batch;
    hrhp_pkg::res_t [hrhp_pkg::MAX_RES-1:0]   res_reg, res_next;
    logic [hrhp_pkg::CNT_W-1:0]               cnt_reg, cnt_next;
    logic                                     take;
    logic                                     pop;

    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign in_stall  = (cnt_reg > hrhp_pkg::CNT_W'(1)) ||
                       ((cnt_reg == hrhp_pkg::CNT_W'(1)) && out_stall);
    assign take      = in_valid && !in_stall;

    hrhp_core u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .take            (take),
        .data_byte       (data_byte),
        .byte_valid      (byte_valid),
        .end_of_response (end_of_response),
        .batch           (batch)
    );

    always_comb
    begin
        res_next = res_reg;
        cnt_next = cnt_reg;
        if (take)
        begin
            res_next = batch.slot;
            cnt_next = batch.count;
        end
        else if (pop)
        begin
            for (int i = 0; i < hrhp_pkg::MAX_RES - 1; i++)
            begin
                res_next[i] = res_reg[i + 1];
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign kind        = res_reg[0].kind;
    assign out_byte    = res_reg[0].data;
    assign status_code = res_reg[0].code;
    assign error_code  = res_reg[0].err;
    assign last_of_run = res_reg[0].last;

    a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> (cnt_reg == $past(batch.count)))
        else $error("result count not loaded on accept");

    a_tail_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == hrhp_pkg::CNT_W'(1)) |-> res_reg[0].last)
        else $error("final buffered result lacks last_of_run");

    a_non_summary_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind != hrhp_pkg::K_SUM) |->
            (status_code == 16'd0 && error_code == hrhp_pkg::ERR_OK))
        else $error("code or error set on a non-summary result");

    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == hrhp_pkg::K_SUM) |-> last_of_run)
        else $error("summary is not the last result of its request");

endmodule
